FILE: sv/fdt_pkg.sv
// shared constants, types and character table for the float to decimal text block
package fdt_pkg;

  // number of fraction digits formed before trailing zeros are dropped
  localparam int FRAC_DIGITS = 5;
  // a 32-bit integer part never needs more than ten decimal digits
  localparam int INT_DIGITS  = 10;

  localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);
  localparam int ICNT_W = $clog2(INT_DIGITS + 1);

  localparam int EXP_BIAS      = 127;
  localparam int MANT_BITS     = 23;
  localparam int EXP_TOO_BIG   = 31;
  localparam int EXP_TOO_SMALL = -23;

  // thresholds on the biased exponent
  localparam logic [7:0] BEXP_BIG   = 8'(EXP_BIAS + EXP_TOO_BIG);
  localparam logic [7:0] BEXP_SMALL = 8'(EXP_BIAS + EXP_TOO_SMALL);
  localparam logic [7:0] BEXP_INT   = 8'(EXP_BIAS + MANT_BITS);
  localparam logic [7:0] BEXP_ONE   = 8'(EXP_BIAS);
  localparam logic [7:0] BEXP_FRAC  = 8'(EXP_BIAS - 1);

  // reciprocal of ten, exact for every 32-bit value with a 35-bit shift
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_I     = 7'h49;
  localparam logic [6:0] CH_N     = 7'h6E;
  localparam logic [6:0] CH_F     = 7'h66;

  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_ZERO,
    CLS_INF,
    CLS_TINY
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC,
    ST_SPEC
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_SIGN,
    EMIT_INT,
    EMIT_DOT,
    EMIT_FRAC,
    EMIT_SPEC
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      step;
    emit_sel_t emit_sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic neg;
    logic conv_done;
    logic int_last;
    logic frac_last;
    logic spec_last;
  } status_t;

  // fixed texts of the special classes
  function automatic logic [6:0] spec_char(input cls_t cls, input logic [1:0] idx);
    logic [6:0] c;
    c = CH_ZERO;
    case (cls)
      CLS_ZERO: begin
        if (idx == 2'd1) c = CH_DOT;
        else             c = CH_ZERO;
      end
      CLS_INF: begin
        if (idx == 2'd0)      c = CH_I;
        else if (idx == 2'd1) c = CH_N;
        else                  c = CH_F;
      end
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

  function automatic logic spec_is_last(input cls_t cls, input logic [1:0] idx);
    logic l;
    case (cls)
      CLS_ZERO: l = (idx == 2'd2);
      CLS_INF:  l = (idx == 2'd2);
      default:  l = 1'b1;
    endcase
    return l;
  endfunction

endpackage

FILE: sv/fdt_ctrl.sv
// sequencing state machine: decode, digit conversion and character emission
module fdt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fdt_pkg::status_t status,
  output fdt_pkg::cmd_t   cmd,
  output logic            busy
);
  import fdt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.emit_sel = EMIT_NONE;
    cmd.last     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (status.cls != CLS_NORMAL) begin
          state_next = ST_SPEC;
        end else if (!status.conv_done) begin
          cmd.step = 1'b1;
        end else if (status.neg) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_INT;
        end
      end
      ST_SIGN: begin
        cmd.emit_sel = EMIT_SIGN;
        state_next   = ST_INT;
      end
      ST_INT: begin
        cmd.emit_sel = EMIT_INT;
        if (status.int_last) state_next = ST_DOT;
      end
      ST_DOT: begin
        cmd.emit_sel = EMIT_DOT;
        state_next   = ST_FRAC;
      end
      ST_FRAC: begin
        cmd.emit_sel = EMIT_FRAC;
        cmd.last     = status.frac_last;
        if (status.frac_last) state_next = ST_IDLE;
      end
      ST_SPEC: begin
        cmd.emit_sel = EMIT_SPEC;
        cmd.last     = status.spec_last;
        if (status.spec_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: sv/fdt_datapath.sv
// operand decode, digit registers and the registered character output
module fdt_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      float_bits,
  input  fdt_pkg::cmd_t    cmd,
  output fdt_pkg::status_t status,
  output logic             char_valid,
  output logic [6:0]       text_char,
  output logic             last_char
);
  import fdt_pkg::*;

  localparam logic [FCNT_W-1:0] FD_CNT = FCNT_W'(FRAC_DIGITS);

  // decode of the incoming request
  logic [7:0]  bexp;
  logic [22:0] mant;
  logic [23:0] sig;
  logic [31:0] sig32;
  logic [7:0]  d_up, d_dn, d_fl, d_fr;
  logic [31:0] frac_sh;
  logic [31:0] ipart_d;
  logic [23:0] fpart_d;
  cls_t        cls_d;

  // working registers
  cls_t             cls;
  logic             neg;
  logic [31:0]      ival;
  logic [23:0]      fval;
  logic             int_done;
  logic [ICNT_W-1:0] icnt;
  logic [FCNT_W-1:0] fk;
  logic [FCNT_W-1:0] fcnt;
  logic [1:0]       sidx;
  logic [3:0]       idig [INT_DIGITS];
  logic [3:0]       fdig [FRAC_DIGITS];

  // one decimal digit step on each part
  logic [63:0] prod;
  logic [28:0] quo;
  logic [31:0] quo_x10;
  logic [3:0]  rem;
  logic [27:0] fprod;
  logic [3:0]  fdigit;
  logic        frac_done;
  logic [6:0]  char_next;

  assign bexp  = float_bits[30:23];
  assign mant  = float_bits[22:0];
  assign sig   = {1'b1, mant};
  assign sig32 = {8'd0, sig};
  assign d_up  = bexp - BEXP_INT;
  assign d_dn  = BEXP_INT - bexp;
  assign d_fl  = bexp - BEXP_FRAC;
  assign d_fr  = BEXP_FRAC - bexp;
  assign frac_sh = sig32 << d_fl[4:0];

  always_comb begin
    ipart_d = '0;
    fpart_d = '0;
    if (bexp >= BEXP_INT) begin
      ipart_d = sig32 << d_up[2:0];
    end else if (bexp >= BEXP_ONE) begin
      ipart_d = sig32 >> d_dn[4:0];
      fpart_d = frac_sh[23:0];
    end else begin
      fpart_d = sig >> d_fr[4:0];
    end
  end

  always_comb begin
    if (bexp == 8'd0 && mant == 23'd0) cls_d = CLS_ZERO;
    else if (bexp >= BEXP_BIG)         cls_d = CLS_INF;
    else if (bexp < BEXP_SMALL)        cls_d = CLS_TINY;
    else                               cls_d = CLS_NORMAL;
  end

  assign prod    = ival * RECIP10;
  assign quo     = prod[63:RECIP_SH];
  assign quo_x10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
  assign rem     = ival[3:0] - quo_x10[3:0];

  assign fprod  = {1'b0, fval, 3'b000} + {3'b000, fval, 1'b0};
  assign fdigit = fprod[27:24];

  assign frac_done = (fk == FD_CNT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cls      <= cls_d;
      neg      <= float_bits[31];
      ival     <= ipart_d;
      fval     <= fpart_d;
      int_done <= 1'b0;
      icnt     <= '0;
      fk       <= '0;
      fcnt     <= FCNT_W'(1);
      sidx     <= '0;
    end else if (cmd.step) begin
      if (!int_done) begin
        ival     <= {3'b000, quo};
        int_done <= (quo == 29'd0);
        icnt     <= icnt + ICNT_W'(1);
        for (int i = 0; i < INT_DIGITS; i++)
          idig[i] <= idig[(i + INT_DIGITS - 1) % INT_DIGITS];
        idig[0] <= rem;
      end
      if (!frac_done) begin
        fval <= fprod[23:0];
        fk   <= fk + FCNT_W'(1);
        if (fdigit != 4'd0) fcnt <= fk + FCNT_W'(1);
        for (int i = 0; i < FRAC_DIGITS; i++)
          fdig[i] <= fdig[(i + 1) % FRAC_DIGITS];
        fdig[FRAC_DIGITS-1] <= fdigit;
      end
    end else begin
      case (cmd.emit_sel)
        EMIT_INT: begin
          icnt <= icnt - ICNT_W'(1);
          for (int i = 0; i < INT_DIGITS; i++)
            idig[i] <= idig[(i + 1) % INT_DIGITS];
        end
        EMIT_FRAC: begin
          fcnt <= fcnt - FCNT_W'(1);
          for (int i = 0; i < FRAC_DIGITS; i++)
            fdig[i] <= fdig[(i + 1) % FRAC_DIGITS];
        end
        EMIT_SPEC: sidx <= sidx + 2'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      EMIT_SIGN: char_next = CH_MINUS;
      EMIT_INT:  char_next = CH_ZERO + {3'b000, idig[0]};
      EMIT_DOT:  char_next = CH_DOT;
      EMIT_FRAC: char_next = CH_ZERO + {3'b000, fdig[0]};
      EMIT_SPEC: char_next = spec_char(cls, sidx);
      default:   char_next = CH_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) char_valid <= 1'b0;
    else     char_valid <= (cmd.emit_sel != EMIT_NONE);
  end

  always_ff @(posedge clk) begin
    text_char <= char_next;
    last_char <= cmd.last;
  end

  assign status.cls       = cls;
  assign status.neg       = neg;
  assign status.conv_done = int_done && frac_done;
  assign status.int_last  = (icnt == ICNT_W'(1));
  assign status.frac_last = (fcnt == FCNT_W'(1));
  assign status.spec_last = spec_is_last(cls, sidx);

endmodule

FILE: sv/float_to_decimal_text_core.sv
// top level: single-precision bit pattern to decimal ascii text, one character per strobe
//
// channel   direction  handshake                 payload
// request   in         start && !busy            float_bits[31:0]
// result    out        char_valid (one cycle)    text_char[6:0], last_char
//
// accepting edge registers the decoded operand; for a number, conversion steps follow,
// each taking an integer digit (reciprocal-of-ten multiply) and a fraction digit
// (times-ten add) until that part is done, then the first source is picked; characters
// leave one per cycle, at most 17, each registered onto the ports from its emit state
// busy falls as the last character is registered; reset is synchronous; no stalls
module float_to_decimal_text_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] float_bits,
  output logic        busy,
  output logic        char_valid,
  output logic [6:0]  text_char,
  output logic        last_char
);
  import fdt_pkg::*;

  // command and status between the sequencer and the datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: decides which character source goes next
  fdt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: decode, digit registers, output register
  fdt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .float_bits (float_bits),
    .cmd        (cmd),
    .status     (status),
    .char_valid (char_valid),
    .text_char  (text_char),
    .last_char  (last_char)
  );

endmodule

FILE: sv/fdt_checker.sv
// port-level checks on the float to decimal text block, with its bind
module fdt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       char_valid,
  input logic [6:0] text_char,
  input logic       last_char
);

  // an accepted request keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // characters only follow a cycle in which the block was busy
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !char_valid)
    else $error("character strobe after an idle cycle");

  // the final character coincides with the block going idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last_char) |-> !busy)
    else $error("last character while still busy");

  // a character seen while idle must close the text
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !busy) |-> last_char)
    else $error("text ended without last flag");

  // characters are printable ascii
  a_printable: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (text_char >= 7'h2D && text_char <= 7'h6E))
    else $error("unexpected character code");

endmodule

bind float_to_decimal_text_core fdt_checker u_fdt_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .char_valid (char_valid),
  .text_char  (text_char),
  .last_char  (last_char)
);
